// ===== hw/rtl/rcsfc_pkg.sv =====
`default_nettype none

package rcsfc_pkg;

   localparam int ADC_BITS = 12;

   // Divider sizing: numerator is a stick offset times 100, denominator a span.
   localparam int NUM_W     = ADC_BITS + 7;
   localparam int DEN_W     = ADC_BITS;
   localparam int DIV_STEPS = (NUM_W + 1) / 2;
   localparam int NUM_PAD   = 2 * DIV_STEPS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_W  = 80;
   localparam int RSP_W  = 48;
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;

   localparam int CMD_MAX         = 100;
   localparam int LINK_TIMEOUT_MS = 1000;
   localparam int BLINK_FAST_MS   = 100;
   localparam int BLINK_SLOW_MS   = 500;

   typedef enum logic [CSR_IW-1:0] {
      CSR_THROTTLE_CENTER = 3'd0,
      CSR_STEER_CENTER    = 3'd1,
      CSR_ADC_FULL_SCALE  = 3'd2,
      CSR_DEAD_BAND       = 3'd3,
      CSR_TRIM_STEP_SIZE  = 3'd4,
      CSR_TRIM_LIMIT      = 3'd5,
      CSR_FRAME_INTERVAL  = 3'd6,
      CSR_TRIM_REPEAT     = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] throttle_center;
      logic [ADC_BITS-1:0] steer_center;
      logic [ADC_BITS-1:0] adc_full_scale;
      logic [6:0]          dead_band;
      logic [6:0]          trim_step_size;
      logic [6:0]          trim_limit;
      logic [15:0]         frame_interval_ms;
      logic [15:0]         trim_gap_ms;
   } cfg_type;

   typedef struct packed {
      logic [ADC_BITS-1:0] raw_throttle;
      logic [ADC_BITS-1:0] raw_steer;
      logic [ADC_BITS-1:0] raw_gain;
      logic                frame_sent;
      logic [7:0]          frame_seq;
      logic signed [1:0]   gyro_direction;
      logic signed [7:0]   trim_now;
      logic                link_up;
      logic                led_level;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   typedef struct packed {
      logic neg;
      logic zero;
      logic low;
   } lane_meta_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rcsfc_front.sv =====
`default_nettype none

module rcsfc_front (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [rcsfc_pkg::REQ_W-1:0]      req_tdata,
   input  rcsfc_pkg::cfg_type               cfg,
   input  rcsfc_pkg::q_stat_type            q_stat,
   output logic                             push,
   output rcsfc_pkg::job_type               push_job
);

   logic signed [7:0] trim_ff, trim_in;
   logic [7:0]        seq_ff, seq_in;
   logic [31:0]       last_frame_ff, last_frame_in;
   logic [31:0]       last_trim_ff, last_trim_in;
   logic [31:0]       last_ack_ff, last_ack_in;
   logic [31:0]       last_blink_ff, last_blink_in;
   logic              link_ff, link_in;
   logic              led_ff, led_in;

   logic [31:0] now_ms;
   logic        press_left, press_right, press_zero, press_reverse, ack_seen;
   logic [31:0] elapsed_trim, elapsed_frame, elapsed_ack, elapsed_blink;
   logic [6:0]  lim;
   logic signed [9:0] trim_wide, step_wide, lim_wide, trim_down, trim_up;
   logic        frame_due;

   function automatic logic signed [7:0] clamp_trim(input logic signed [9:0] v,
                                                    input logic signed [9:0] l);
      logic signed [9:0] r;
      r = v;
      if (v < -l) r = -l;
      if (v > l)  r = l;
      return r[7:0];
   endfunction

   assign now_ms        = req_tdata[31:0];
   assign press_left    = req_tdata[68];
   assign press_right   = req_tdata[69];
   assign press_zero    = req_tdata[70];
   assign press_reverse = req_tdata[71];
   assign ack_seen      = req_tdata[72];

   assign req_tready = !q_stat.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      elapsed_trim  = now_ms - last_trim_ff;
      elapsed_frame = now_ms - last_frame_ff;
      elapsed_ack   = now_ms - last_ack_ff;
      elapsed_blink = now_ms - last_blink_ff;

      lim       = (cfg.trim_limit > 7'(rcsfc_pkg::CMD_MAX)) ? 7'(rcsfc_pkg::CMD_MAX)
                                                             : cfg.trim_limit;
      trim_wide = {{2{trim_ff[7]}}, trim_ff};
      step_wide = {3'b000, cfg.trim_step_size};
      lim_wide  = {3'b000, lim};
      trim_down = trim_wide - step_wide;
      trim_up   = trim_wide + step_wide;

      last_ack_in = ack_seen ? now_ms : last_ack_ff;

      trim_in      = trim_ff;
      last_trim_in = last_trim_ff;
      if (elapsed_trim >= {16'h0000, cfg.trim_gap_ms}) begin
         if (press_zero) begin
            trim_in = 8'sd0;
         end else if (press_left) begin
            trim_in = clamp_trim(trim_down, lim_wide);
         end else if (press_right) begin
            trim_in = clamp_trim(trim_up, lim_wide);
         end
         if (press_left || press_right || press_zero) begin
            last_trim_in = now_ms;
         end
      end

      frame_due     = elapsed_frame >= {16'h0000, cfg.frame_interval_ms};
      last_frame_in = frame_due ? now_ms : last_frame_ff;
      seq_in        = frame_due ? seq_ff + 8'd1 : seq_ff;

      // A fresh ack restarts the timeout, so only the old timestamp can expire.
      link_in = ack_seen ||
                (link_ff && !(elapsed_ack > 32'(rcsfc_pkg::LINK_TIMEOUT_MS)));

      last_blink_in = last_blink_ff;
      led_in        = led_ff;
      if (elapsed_blink > (link_in ? 32'(rcsfc_pkg::BLINK_FAST_MS)
                                   : 32'(rcsfc_pkg::BLINK_SLOW_MS))) begin
         last_blink_in = now_ms;
         led_in        = !led_ff;
      end

      push_job.raw_throttle   = req_tdata[43:32];
      push_job.raw_steer      = req_tdata[55:44];
      push_job.raw_gain       = req_tdata[67:56];
      push_job.frame_sent     = frame_due;
      push_job.frame_seq      = frame_due ? seq_in : 8'd0;
      push_job.gyro_direction = press_reverse ? -2'sd1 : 2'sd1;
      push_job.trim_now       = trim_in;
      push_job.link_up        = link_in;
      push_job.led_level      = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trim_ff       <= 8'sd0;
         seq_ff        <= 8'd0;
         last_frame_ff <= 32'd0;
         last_trim_ff  <= 32'd0;
         last_ack_ff   <= 32'd0;
         last_blink_ff <= 32'd0;
         link_ff       <= 1'b0;
         led_ff        <= 1'b1;
      end else if (push) begin
         trim_ff       <= trim_in;
         seq_ff        <= seq_in;
         last_frame_ff <= last_frame_in;
         last_trim_ff  <= last_trim_in;
         last_ack_ff   <= last_ack_in;
         last_blink_ff <= last_blink_in;
         link_ff       <= link_in;
         led_ff        <= led_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rcsfc_queue.sv =====
`default_nettype none

module rcsfc_queue (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  rcsfc_pkg::job_type        push_job,
   input  wire                       pop,
   output rcsfc_pkg::job_type        head_job,
   output rcsfc_pkg::q_stat_type     q_stat
);

   rcsfc_pkg::job_type mem_ff [rcsfc_pkg::QUEUE_DEPTH];

   logic [rcsfc_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [rcsfc_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [rcsfc_pkg::Q_CNT_W-1:0] count_ff, count_in;

   localparam logic [rcsfc_pkg::Q_PTR_W-1:0] LAST_PTR =
      rcsfc_pkg::Q_PTR_W'(rcsfc_pkg::QUEUE_DEPTH - 1);
   localparam logic [rcsfc_pkg::Q_CNT_W-1:0] FULL_CNT =
      rcsfc_pkg::Q_CNT_W'(rcsfc_pkg::QUEUE_DEPTH);

   assign q_stat.full  = count_ff == FULL_CNT;
   assign q_stat.empty = count_ff == '0;
   assign head_job     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!q_stat.full || pop))
      else $error("request pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from an empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/rcsfc_div.sv =====
`default_nettype none

module rcsfc_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [rcsfc_pkg::NUM_W-1:0]      num,
   input  wire  [rcsfc_pkg::DEN_W-1:0]      den,
   output logic [rcsfc_pkg::NUM_W-1:0]      quot,
   output rcsfc_pkg::div_stat_type          stat
);

   localparam int DW = rcsfc_pkg::DEN_W;
   localparam int PW = rcsfc_pkg::NUM_PAD;
   localparam logic [rcsfc_pkg::DIV_CNT_W-1:0] LAST_CNT =
      rcsfc_pkg::DIV_CNT_W'(rcsfc_pkg::DIV_STEPS - 1);

   logic                            busy_ff, busy_in;
   logic [rcsfc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PW-1:0]                   work_ff, work_in;
   logic [PW-1:0]                   quot_ff, quot_in;
   logic [DW-1:0]                   rem_ff, rem_in;
   logic [DW-1:0]                   den_ff, den_in;

   logic [DW:0]   try_hi, try_lo;
   logic [DW-1:0] rem_mid;
   logic          bit_hi, bit_lo;

   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == LAST_CNT);
   assign quot      = quot_ff[rcsfc_pkg::NUM_W-1:0];

   // Two restoring steps per cycle; the remainder stays below the divisor when the divisor is nonzero.
   always_comb begin
      try_hi  = {rem_ff, work_ff[PW-1]};
      bit_hi  = try_hi >= {1'b0, den_ff};
      rem_mid = bit_hi ? DW'(try_hi - {1'b0, den_ff}) : try_hi[DW-1:0];
      try_lo  = {rem_mid, work_ff[PW-2]};
      bit_lo  = try_lo >= {1'b0, den_ff};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         work_in = PW'(num);
         quot_in = '0;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         work_in = {work_ff[PW-3:0], 2'b00};
         quot_in = {quot_ff[PW-3:0], bit_hi, bit_lo};
         rem_in  = bit_lo ? DW'(try_lo - {1'b0, den_ff}) : try_lo[DW-1:0];
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rcsfc_back.sv =====
`default_nettype none

module rcsfc_back (
   input  wire                              clock,
   input  wire                              reset,
   input  rcsfc_pkg::cfg_type               cfg,
   input  rcsfc_pkg::q_stat_type            q_stat,
   input  rcsfc_pkg::job_type               head_job,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [rcsfc_pkg::RSP_W-1:0]      rsp_tdata
);

   localparam int AB = rcsfc_pkg::ADC_BITS;
   localparam int NW = rcsfc_pkg::NUM_W;
   localparam int DW = rcsfc_pkg::DEN_W;
   localparam int VW = rcsfc_pkg::NUM_W + 2;
   localparam int LANES = 3;
   localparam logic signed [VW-1:0] V_MAX = VW'(rcsfc_pkg::CMD_MAX);
   localparam logic signed [8:0]    S_MAX = 9'(rcsfc_pkg::CMD_MAX);

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_DIV  = 3'b010,
      B_POST = 3'b100
   } back_state_type;

   typedef struct packed {
      logic [NW-1:0]            num;
      logic [DW-1:0]            den;
      rcsfc_pkg::lane_meta_type meta;
   } lane_setup_type;

   back_state_type state_ff, state_in;

   rcsfc_pkg::job_type       job_ff;
   rcsfc_pkg::lane_meta_type meta_ff [LANES];
   lane_setup_type           setup [LANES];
   logic [NW-1:0]            quot [LANES];
   rcsfc_pkg::div_stat_type  dstat [LANES];
   logic [LANES-1:0]         lane_done;

   logic                     start;
   logic                     out_load;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     o_sent_ff;
   logic signed [7:0]        o_throttle_ff, o_steer_ff, o_trim_ff;
   logic [7:0]               o_seq_ff;
   logic [6:0]               o_gain_ff;
   logic signed [1:0]        o_dir_ff;
   logic                     o_link_ff, o_led_ff;

   logic signed [7:0]        thr_v, str_v;
   logic signed [8:0]        str_sum;
   logic signed [7:0]        str_trim;
   logic [6:0]               gain_v;

   function automatic lane_setup_type stick_setup(input logic [AB-1:0] r,
                                                  input logic [AB-1:0] c,
                                                  input logic [AB-1:0] f);
      lane_setup_type s;
      logic signed [AB:0] span;
      span = $signed({1'b0, f}) - $signed({1'b0, c});
      if (r >= c) begin
         s.num       = NW'(r - c) * NW'(rcsfc_pkg::CMD_MAX);
         s.den       = span[AB] ? DW'(-span) : DW'(span[AB-1:0]);
         s.meta.neg  = span[AB];
         s.meta.zero = span == '0;
         s.meta.low  = 1'b0;
      end else begin
         // Below center the span is the center itself, which is above zero here.
         s.num       = NW'(r) * NW'(rcsfc_pkg::CMD_MAX);
         s.den       = DW'(c);
         s.meta.neg  = 1'b0;
         s.meta.zero = 1'b0;
         s.meta.low  = 1'b1;
      end
      return s;
   endfunction

   function automatic logic signed [7:0] stick_post(input logic [NW-1:0] q,
                                                    input rcsfc_pkg::lane_meta_type m,
                                                    input logic [6:0] db);
      logic signed [VW-1:0] v;
      logic signed [7:0]    c8;
      logic [7:0]           mag;
      v = $signed({2'b00, q});
      if (m.neg) v = -v;
      if (m.low) v = v - V_MAX;
      if (m.zero) v = '0;
      if (v < -V_MAX) v = -V_MAX;
      if (v > V_MAX)  v = V_MAX;
      c8  = v[7:0];
      mag = c8[7] ? 8'(-c8) : 8'(c8);
      if (mag <= {1'b0, db}) c8 = 8'sd0;
      return c8;
   endfunction

   always_comb begin
      setup[0] = stick_setup(head_job.raw_throttle, cfg.throttle_center, cfg.adc_full_scale);
      setup[1] = stick_setup(head_job.raw_steer, cfg.steer_center, cfg.adc_full_scale);
      setup[2].num       = NW'(head_job.raw_gain) * NW'(rcsfc_pkg::CMD_MAX);
      setup[2].den       = DW'(cfg.adc_full_scale);
      setup[2].meta.neg  = 1'b0;
      setup[2].meta.zero = cfg.adc_full_scale == '0;
      setup[2].meta.low  = 1'b0;
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      rcsfc_div u_div (
         .clock (clock),
         .reset (reset),
         .start (start),
         .num   (setup[i].num),
         .den   (setup[i].den),
         .quot  (quot[i]),
         .stat  (dstat[i])
      );
      assign lane_done[i] = dstat[i].done;

      always_ff @(posedge clock) begin
         if (start) begin
            meta_ff[i] <= setup[i].meta;
         end
      end
   end

   always_comb begin
      thr_v    = stick_post(quot[0], meta_ff[0], cfg.dead_band);
      str_v    = stick_post(quot[1], meta_ff[1], cfg.dead_band);
      str_sum  = $signed({str_v[7], str_v}) + $signed({job_ff.trim_now[7], job_ff.trim_now});
      str_trim = str_sum[7:0];
      if (str_sum > S_MAX)  str_trim = S_MAX[7:0];
      if (str_sum < -S_MAX) str_trim = 8'(-S_MAX);
      if (meta_ff[2].zero) begin
         gain_v = 7'd0;
      end else if (quot[2] > NW'(rcsfc_pkg::CMD_MAX)) begin
         gain_v = 7'(rcsfc_pkg::CMD_MAX);
      end else begin
         gain_v = quot[2][6:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      start    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_stat.empty) begin
               start    = 1'b1;
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (&lane_done) begin
               state_in = B_POST;
            end
         end
         B_POST: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   assign pop = start;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         job_ff <= head_job;
      end
      if (out_load) begin
         o_sent_ff     <= job_ff.frame_sent;
         o_throttle_ff <= job_ff.frame_sent ? thr_v : 8'sd0;
         o_steer_ff    <= job_ff.frame_sent ? str_trim : 8'sd0;
         o_seq_ff      <= job_ff.frame_seq;
         o_gain_ff     <= gain_v;
         o_dir_ff      <= job_ff.gyro_direction;
         o_trim_ff     <= job_ff.trim_now;
         o_link_ff     <= job_ff.link_up;
         o_led_ff      <= job_ff.led_level;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'h0, o_led_ff, o_link_ff, o_trim_ff, o_dir_ff, o_gain_ff,
                        o_seq_ff, o_steer_ff, o_throttle_ff, o_sent_ff};

   a_div_running: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_DIV) |-> (dstat[0].busy && dstat[1].busy && dstat[2].busy))
      else $error("divider lanes idle while a request is being divided");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      out_load |=> rsp_valid_ff)
      else $error("loaded result not presented");

   a_no_frame_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !o_sent_ff) |->
      (o_throttle_ff == 8'sd0 && o_steer_ff == 8'sd0 && o_seq_ff == 8'd0))
      else $error("frame fields set in a pass without a frame");

   a_cmd_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (o_gain_ff <= 7'd100 && o_throttle_ff <= 8'sd100 &&
                        o_throttle_ff >= -8'sd100 && o_steer_ff <= 8'sd100 &&
                        o_steer_ff >= -8'sd100))
      else $error("command outside the percent range");

endmodule

`default_nettype wire

// ===== hw/rtl/rc_stick_frame_conditioner.sv =====
`default_nettype none

// Channel   Direction  tdata fields, lowest bit up
// req_      in         now_ms 32, raw_throttle 12, raw_steer 12, raw_gain 12,
//                      press_left, press_right, press_zero, press_reverse, ack_seen
// rsp_      out        frame_sent, throttle_cmd 8, steer_cmd 8, frame_seq 8,
//                      gain_cmd 7, gyro_direction 2, trim_now 8, link_up, led_level
// csr_      in         write enable, register index 3, write data 16
//
// A request is accepted whenever the two-entry queue has room; the
// timing, trim, link and LED state is updated at the accepting edge.
// The back end takes each request through B_IDLE, which starts the divider lanes,
// B_DIV (three lanes, two quotient bits per cycle each) and B_POST, which loads the output.
// The result register lets the back end start the next request while a result waits.
// Reset is synchronous and restores control and config state to defaults; no clearing pass.
module rc_stick_frame_conditioner (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // now_ms, raw_throttle, raw_steer, raw_gain, press_left, press_right,
   // press_zero, press_reverse, ack_seen
   input  wire  [rcsfc_pkg::REQ_W-1:0]      req_tdata,
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // frame_sent, throttle_cmd, steer_cmd, frame_seq, gain_cmd, gyro_direction,
   // trim_now, link_up, led_level
   output logic [rcsfc_pkg::RSP_W-1:0]      rsp_tdata,
   input  wire                              csr_we,
   input  wire  [rcsfc_pkg::CSR_IW-1:0]     csr_index,
   input  wire  [rcsfc_pkg::CSR_DW-1:0]     csr_wdata
);

   localparam int AB = rcsfc_pkg::ADC_BITS;

   rcsfc_pkg::cfg_type    cfg_ff, cfg_in;
   rcsfc_pkg::q_stat_type q_stat;
   rcsfc_pkg::job_type    push_job, head_job;
   logic                  push, pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (rcsfc_pkg::csr_idx_type'(csr_index))
            rcsfc_pkg::CSR_THROTTLE_CENTER: cfg_in.throttle_center   = csr_wdata[AB-1:0];
            rcsfc_pkg::CSR_STEER_CENTER:    cfg_in.steer_center      = csr_wdata[AB-1:0];
            rcsfc_pkg::CSR_ADC_FULL_SCALE:  cfg_in.adc_full_scale    = csr_wdata[AB-1:0];
            rcsfc_pkg::CSR_DEAD_BAND:       cfg_in.dead_band         = csr_wdata[6:0];
            rcsfc_pkg::CSR_TRIM_STEP_SIZE:  cfg_in.trim_step_size    = csr_wdata[6:0];
            rcsfc_pkg::CSR_TRIM_LIMIT:      cfg_in.trim_limit        = csr_wdata[6:0];
            rcsfc_pkg::CSR_FRAME_INTERVAL:  cfg_in.frame_interval_ms = csr_wdata;
            rcsfc_pkg::CSR_TRIM_REPEAT:     cfg_in.trim_gap_ms       = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.throttle_center   <= AB'(2047);
         cfg_ff.steer_center      <= AB'(2047);
         cfg_ff.adc_full_scale    <= AB'(4095);
         cfg_ff.dead_band         <= 7'd5;
         cfg_ff.trim_step_size    <= 7'd1;
         cfg_ff.trim_limit        <= 7'd30;
         cfg_ff.frame_interval_ms <= 16'd20;
         cfg_ff.trim_gap_ms       <= 16'd150;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcsfc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .push       (push),
      .push_job   (push_job)
   );

   rcsfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   rcsfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_stat     (q_stat),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
